### hw/rtl/gfph_pkg.sv
package gfph_pkg;

    // Channel limit of one fleet.
    localparam int unsigned MAX_CHANNELS = 8;

    // Field widths.
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned UNIT_W     = 4;
    localparam int unsigned RATED_W    = 27;
    localparam int unsigned MEAS_W     = 27;
    localparam int unsigned REQ_W      = 28;
    localparam int unsigned HEAD_W     = 23;
    localparam int unsigned S_DATA_W   = 144;
    localparam int unsigned M_DATA_W   = 112;

    // Saturation limits of the counters and sums.
    localparam logic [IDX_W-1:0]   IDX_MAX   = '1;
    localparam logic [UNIT_W-1:0]  UNIT_MAX  = '1;
    localparam logic [RATED_W-1:0] RATED_MAX = '1;
    localparam logic [MEAS_W-1:0]  MEAS_MAX  = '1;
    localparam logic [REQ_W-1:0]   REQ_MAX   = '1;

    // Loading is in 0.01 %, so full load is 10000.
    localparam logic signed [15:0] LOAD_FULL  = 16'sd10000;
    localparam logic [36:0]        ROUND_HALF = 37'd5000;

    // floor(x / 10000) == (x * RECIP_M) >> RECIP_SHIFT for x below 1.5e11.
    localparam logic [36:0] RECIP_M     = 37'd112589990685;
    localparam int unsigned RECIP_SHIFT = 50;
    localparam logic [18:0] RECIP_ML    = RECIP_M[18:0];
    localparam logic [17:0] RECIP_MH    = RECIP_M[36:19];

    // Decoded channel, carried along the pipeline.
    typedef struct packed {
        logic              cfg;
        logic              param_bad;
        logic              closed_stopped;
        logic              closed;
        logic              meter_bad;
        logic [22:0]       rating;
        logic [22:0]       metered;
        logic [22:0]       reserve;
        logic [22:0]       margin;
        logic signed [23:0] load;
        logic              last;
    } chan_t;

endpackage

### hw/rtl/generator_fleet_pv_headroom_top.sv
// Generator fleet aggregation with PV headroom. Each input transfer carries one
// generator channel; s_tlast marks the final channel of a fleet. Commissioned
// channels are checked (fresh evidence, positive rating, loading 0..100.00 %,
// non-negative reserve and margin, no closed breaker on a stopped machine, and a
// fresh non-negative meter reading on a closed breaker); the first failure, or
// any channel past gfph_pkg::MAX_CHANNELS, latches a conflict and the rest of
// the fleet is ignored. Closed-breaker channels add to a unit count and to
// saturating sums of rated, measured and required minimum power, where the
// required minimum is rating * loading / 10000 rounded half up, plus reserve,
// plus margin. The final channel produces one result transfer carrying validity,
// conflict, the count, the sums and the PV headroom (load minus required sum,
// floored at zero); all sums and the headroom read zero when the result is not
// valid, and the fleet state clears for the next fleet. Throughput is one
// channel per clock while the pipeline is not held. A result travels from the
// input register through a decode and product stage, a reciprocal
// partial-product stage, a quotient stage and a required-power stage, and
// finally from the accumulator stage into the output register. The pipeline
// only holds when a final channel reaches the accumulator while the previous
// result has not been taken; items that produce no result keep flowing past
// a waiting result.
module generator_fleet_pv_headroom_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // From bit 0: channel_configured, evidence_ok, breaker_is_closed,
    // machine_running, meter_fresh, rating_kw[23:0], min_loading[15:0],
    // reserve_power[23:0], reverse_margin[23:0], metered_kw[23:0],
    // facility_load[23:0], then three zero bits.
    input  logic [gfph_pkg::S_DATA_W-1:0]  s_tdata,
    // last_channel.
    input  logic                           s_tlast,
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // From bit 0: fleet_valid, fleet_conflict, running_units[3:0],
    // total_rated[26:0], total_measured[26:0], total_required[27:0],
    // pv_headroom[22:0], then one zero bit.
    output logic [gfph_pkg::M_DATA_W-1:0]  m_tdata
);

    // Pipeline valids and stage enables. A stage loads when it is empty or
    // when the stage after it loads this cycle.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en2, en3, en4, en5;
    logic fire5;
    logic out_free;

    // Stage 1: raw input register.
    logic [gfph_pkg::S_DATA_W-1:0] d1_reg;
    logic                          last1_reg;

    // Stage 2: decoded channel and rating * loading.
    gfph_pkg::chan_t ch2_reg, ch2_next;
    logic [36:0]     prod2_reg, prod2_next;

    // Stage 3: partial products of (prod + 5000) * RECIP_M.
    gfph_pkg::chan_t ch3_reg;
    logic [37:0]     pp_ll_reg, pp_ll_next;
    logic [36:0]     pp_lh_reg, pp_lh_next;
    logic [36:0]     pp_hl_reg, pp_hl_next;
    logic [35:0]     pp_hh_reg, pp_hh_next;
    logic [36:0]     x3;

    // Stage 4: rounded quotient.
    gfph_pkg::chan_t ch4_reg;
    logic [23:0]     q4_reg, q4_next;
    logic [73:0]     sum4;

    // Stage 5: required minimum power of this channel.
    gfph_pkg::chan_t ch5_reg;
    logic [25:0]     req5_reg, req5_next;

    // Fleet state.
    logic [gfph_pkg::IDX_W-1:0]   chan_idx_reg, chan_idx_next;
    logic [gfph_pkg::UNIT_W-1:0]  units_reg, units_next;
    logic [gfph_pkg::RATED_W-1:0] rated_reg, rated_next;
    logic [gfph_pkg::MEAS_W-1:0]  meas_reg, meas_next;
    logic [gfph_pkg::REQ_W-1:0]   req_sum_reg, req_sum_next;
    logic                         seen_reg, seen_next;
    logic                         conflict_reg, conflict_next;

    logic                         over_limit;
    logic                         chan_fail;
    logic [gfph_pkg::RATED_W:0]   rated_add;
    logic [gfph_pkg::MEAS_W:0]    meas_add;
    logic [gfph_pkg::REQ_W:0]     req_add;

    // Result.
    logic                          res_valid;
    logic [gfph_pkg::HEAD_W-1:0]   head;
    logic                          m_tvalid_reg;
    logic [gfph_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    // Handshake and stall chain. Only a final channel needs the output slot.
    assign out_free = !m_tvalid_reg || m_tready;
    assign fire5    = v5_reg && (!ch5_reg.last || out_free);
    assign en5      = !v5_reg || fire5;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign s_tready = !v1_reg || en2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (s_tready) v1_reg <= s_tvalid;
            if (en2)      v2_reg <= v1_reg;
            if (en3)      v3_reg <= v2_reg;
            if (en4)      v4_reg <= v3_reg;
            if (en5)      v5_reg <= v4_reg;
        end
    end

    // Stage 2 decode: every range check of a channel except the meter and
    // the fleet state, which are judged in the accumulator stage.
    always_comb begin
        logic signed [23:0] rating_s;
        logic signed [15:0] loading_s;
        logic signed [23:0] reserve_s;
        logic signed [23:0] margin_s;
        logic signed [23:0] metered_s;
        rating_s  = $signed(d1_reg[28:5]);
        loading_s = $signed(d1_reg[44:29]);
        reserve_s = $signed(d1_reg[68:45]);
        margin_s  = $signed(d1_reg[92:69]);
        metered_s = $signed(d1_reg[116:93]);

        ch2_next.cfg            = d1_reg[0];
        ch2_next.param_bad      = !d1_reg[1] || (rating_s <= 24'sd0) ||
                                  (loading_s < 16'sd0) ||
                                  (loading_s > gfph_pkg::LOAD_FULL) ||
                                  (reserve_s < 24'sd0) || (margin_s < 24'sd0);
        ch2_next.closed_stopped = d1_reg[2] && !d1_reg[3];
        ch2_next.closed         = d1_reg[2];
        ch2_next.meter_bad      = !d1_reg[4] || metered_s[23];
        ch2_next.rating         = rating_s[22:0];
        ch2_next.metered        = metered_s[22:0];
        ch2_next.reserve        = reserve_s[22:0];
        ch2_next.margin         = margin_s[22:0];
        ch2_next.load           = $signed(d1_reg[140:117]);
        ch2_next.last           = last1_reg;

        // Only used when the checks pass, so loading fits in 14 bits.
        prod2_next = {14'b0, rating_s[22:0]} * {23'b0, loading_s[13:0]};
    end

    // Stage 3: reciprocal multiply split into four partial products.
    assign x3         = prod2_reg + gfph_pkg::ROUND_HALF;
    assign pp_ll_next = {19'b0, x3[18:0]}  * {19'b0, gfph_pkg::RECIP_ML};
    assign pp_lh_next = {18'b0, x3[18:0]}  * {19'b0, gfph_pkg::RECIP_MH};
    assign pp_hl_next = {19'b0, x3[36:19]} * {18'b0, gfph_pkg::RECIP_ML};
    assign pp_hh_next = {18'b0, x3[36:19]} * {18'b0, gfph_pkg::RECIP_MH};

    // Stage 4: combine the partial products and keep the quotient.
    assign sum4 = {36'b0, pp_ll_reg} + ({37'b0, pp_lh_reg} << 19) +
                  ({37'b0, pp_hl_reg} << 19) + ({38'b0, pp_hh_reg} << 38);
    assign q4_next = sum4[73:gfph_pkg::RECIP_SHIFT];

    // Stage 5: required minimum = quotient + reserve + margin.
    assign req5_next = {2'b0, q4_reg} + {3'b0, ch4_reg.reserve} +
                       {3'b0, ch4_reg.margin};

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            d1_reg    <= s_tdata;
            last1_reg <= s_tlast;
        end
        if (en2) begin
            ch2_reg   <= ch2_next;
            prod2_reg <= prod2_next;
        end
        if (en3) begin
            ch3_reg   <= ch2_reg;
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next;
            pp_hh_reg <= pp_hh_next;
        end
        if (en4) begin
            ch4_reg <= ch3_reg;
            q4_reg  <= q4_next;
        end
        if (en5) begin
            ch5_reg  <= ch4_reg;
            req5_reg <= req5_next;
        end
    end

    // Accumulator stage: fleet state after the channel in stage 5.
    assign over_limit = chan_idx_reg >= gfph_pkg::IDX_W'(gfph_pkg::MAX_CHANNELS);
    assign chan_fail  = ch5_reg.param_bad || ch5_reg.closed_stopped ||
                        (ch5_reg.closed && ch5_reg.meter_bad);
    assign rated_add  = {1'b0, rated_reg} + {5'b0, ch5_reg.rating};
    assign meas_add   = {1'b0, meas_reg} + {5'b0, ch5_reg.metered};
    assign req_add    = {1'b0, req_sum_reg} + {3'b0, req5_reg};

    always_comb begin
        units_next    = units_reg;
        rated_next    = rated_reg;
        meas_next     = meas_reg;
        req_sum_next  = req_sum_reg;
        seen_next     = seen_reg;
        conflict_next = conflict_reg;
        chan_idx_next = (chan_idx_reg == gfph_pkg::IDX_MAX) ? chan_idx_reg
                                                            : chan_idx_reg + 1'b1;
        if (over_limit) begin
            conflict_next = 1'b1;
        end else if (!conflict_reg && ch5_reg.cfg) begin
            seen_next = 1'b1;
            if (chan_fail) begin
                conflict_next = 1'b1;
            end else if (ch5_reg.closed) begin
                if (units_reg != gfph_pkg::UNIT_MAX) units_next = units_reg + 1'b1;
                rated_next   = rated_add[gfph_pkg::RATED_W] ? gfph_pkg::RATED_MAX
                                                            : rated_add[gfph_pkg::RATED_W-1:0];
                meas_next    = meas_add[gfph_pkg::MEAS_W] ? gfph_pkg::MEAS_MAX
                                                          : meas_add[gfph_pkg::MEAS_W-1:0];
                req_sum_next = req_add[gfph_pkg::REQ_W] ? gfph_pkg::REQ_MAX
                                                        : req_add[gfph_pkg::REQ_W-1:0];
            end
        end
    end

    // Result fields, built from the state after the final channel.
    assign res_valid = seen_next && !conflict_next && (units_next != '0);

    always_comb begin
        head = '0;
        if (res_valid && !ch5_reg.load[23] &&
            ({5'b0, ch5_reg.load[22:0]} > req_sum_next)) begin
            head = ch5_reg.load[22:0] - req_sum_next[22:0];
        end
        m_data_next = {1'b0, head,
                       res_valid ? req_sum_next : '0,
                       res_valid ? meas_next    : '0,
                       res_valid ? rated_next   : '0,
                       res_valid ? units_next   : '0,
                       conflict_next, res_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_idx_reg <= '0;
            units_reg    <= '0;
            rated_reg    <= '0;
            meas_reg     <= '0;
            req_sum_reg  <= '0;
            seen_reg     <= 1'b0;
            conflict_reg <= 1'b0;
        end else if (fire5) begin
            if (ch5_reg.last) begin
                chan_idx_reg <= '0;
                units_reg    <= '0;
                rated_reg    <= '0;
                meas_reg     <= '0;
                req_sum_reg  <= '0;
                seen_reg     <= 1'b0;
                conflict_reg <= 1'b0;
            end else begin
                chan_idx_reg <= chan_idx_next;
                units_reg    <= units_next;
                rated_reg    <= rated_next;
                meas_reg     <= meas_next;
                req_sum_reg  <= req_sum_next;
                seen_reg     <= seen_next;
                conflict_reg <= conflict_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fire5 && ch5_reg.last) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire5 && ch5_reg.last) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // A valid fleet result always counts at least one running unit.
    a_valid_has_units: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_data_reg[0] |-> m_data_reg[5:2] != '0)
        else $error("valid fleet result with zero running units");

    // An invalid result carries no count, sums or headroom.
    a_invalid_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_data_reg[0] |-> m_data_reg[110:2] == '0)
        else $error("invalid fleet result with nonzero sums");

    // A result is never both valid and in conflict.
    a_valid_no_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_data_reg[0] && m_data_reg[1]))
        else $error("fleet result both valid and in conflict");

    // Retiring a final channel clears the fleet state.
    a_fleet_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        fire5 && ch5_reg.last |=> chan_idx_reg == '0 && !conflict_reg && !seen_reg)
        else $error("fleet state not cleared after final channel");

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

// Checks the generator fleet aggregator against a predictor built into the
// bench. Channels are pushed through the input stream one transfer at a time,
// grouped into fleets by s_tlast. Each accepted channel updates the predicted
// fleet state, and each final channel queues the result that the block must
// return. The result stream is checked in order, field by field.
module testbench;

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    // Input word, highest field first so that configured lands in bit 0.
    typedef struct packed {
        logic [2:0]         pad;
        logic signed [23:0] facility_load;
        logic signed [23:0] metered;
        logic signed [23:0] margin;
        logic signed [23:0] reserve;
        logic signed [15:0] loading;
        logic signed [23:0] rating;
        logic               meter_fresh;
        logic               machine_running;
        logic               breaker_on;
        logic               evidence_ok;
        logic               configured;
    } channel_word_t;

    // Result word, fleet_valid in bit 0.
    typedef struct packed {
        logic                         pad;
        logic [gfph_pkg::HEAD_W-1:0]  headroom;
        logic [gfph_pkg::REQ_W-1:0]   required;
        logic [gfph_pkg::MEAS_W-1:0]  measured;
        logic [gfph_pkg::RATED_W-1:0] rated;
        logic [gfph_pkg::UNIT_W-1:0]  units;
        logic                         conflict;
        logic                         valid;
    } fleet_result_t;

    // Status flag patterns, from bit 0: configured, evidence, breaker closed,
    // machine running, meter fresh.
    localparam logic [4:0] CLOSED_OK      = 5'b11111;
    localparam logic [4:0] OPEN_OK        = 5'b11011;
    localparam logic [4:0] UNCOMMISSIONED = 5'b11110;
    localparam logic [4:0] NO_EVIDENCE    = 5'b11101;
    localparam logic [4:0] STOPPED_CLOSED = 5'b10111;
    localparam logic [4:0] STALE_METER    = 5'b01111;

    // Running fleet state and the queue of fleet results still owed by the
    // block. A channel goes in through take_channel, a result is checked by
    // check_fleet_result.
    class fleet_tally;
        logic [gfph_pkg::UNIT_W-1:0]  unit_count;
        logic [gfph_pkg::RATED_W-1:0] rated_sum;
        logic [gfph_pkg::MEAS_W-1:0]  measured_sum;
        logic [gfph_pkg::REQ_W-1:0]   required_sum;
        logic [gfph_pkg::IDX_W-1:0]   channel_index;
        bit                           seen_configured;
        bit                           conflict;
        fleet_result_t                results_due[$];
        int                           mismatch_count;

        function new();
            clear_fleet();
            mismatch_count = 0;
        endfunction

        function void clear_fleet();
            unit_count      = '0;
            rated_sum       = '0;
            measured_sum    = '0;
            required_sum    = '0;
            channel_index   = '0;
            seen_configured = 1'b0;
            conflict        = 1'b0;
        endfunction

        function longint add_clamped(longint a, longint b, longint ceiling);
            return (a + b > ceiling) ? ceiling : a + b;
        endfunction

        function void take_channel(channel_word_t c, logic last);
            longint        rating;
            longint        loading;
            longint        reserve;
            longint        margin;
            longint        metered;
            longint        load;
            longint        req;
            fleet_result_t r;
            rating  = c.rating;
            loading = c.loading;
            reserve = c.reserve;
            margin  = c.margin;
            metered = c.metered;
            load    = c.facility_load;

            if (channel_index >= gfph_pkg::MAX_CHANNELS) begin
                // Any channel past the fleet limit is a conflict.
                conflict = 1'b1;
            end else if (!conflict && c.configured) begin
                seen_configured = 1'b1;
                if (!c.evidence_ok || rating <= 0 || loading < 0 ||
                    loading > gfph_pkg::LOAD_FULL || reserve < 0 || margin < 0 ||
                    (c.breaker_on && !c.machine_running)) begin
                    conflict = 1'b1;
                end else if (c.breaker_on) begin
                    if (!c.meter_fresh || metered < 0) begin
                        conflict = 1'b1;
                    end else begin
                        // Loading is in 0.01 %, rounded half up.
                        req = (rating * loading + 5000) / 10000 + reserve + margin;
                        if (unit_count != gfph_pkg::UNIT_MAX) unit_count++;
                        rated_sum    = gfph_pkg::RATED_W'(add_clamped(longint'(rated_sum),
                                           rating, longint'(gfph_pkg::RATED_MAX)));
                        measured_sum = gfph_pkg::MEAS_W'(add_clamped(longint'(measured_sum),
                                           metered, longint'(gfph_pkg::MEAS_MAX)));
                        required_sum = gfph_pkg::REQ_W'(add_clamped(longint'(required_sum),
                                           req, longint'(gfph_pkg::REQ_MAX)));
                    end
                end
            end
            if (channel_index != gfph_pkg::IDX_MAX) channel_index++;
            if (!last) return;

            r          = '0;
            r.valid    = seen_configured && !conflict && unit_count != 0;
            r.conflict = conflict;
            if (r.valid) begin
                r.units    = unit_count;
                r.rated    = rated_sum;
                r.measured = measured_sum;
                r.required = required_sum;
                if (load >= 0 && load > longint'(required_sum)) begin
                    r.headroom = gfph_pkg::HEAD_W'(load - longint'(required_sum));
                end
            end
            results_due.push_back(r);
            clear_fleet();
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_fleet_result(fleet_result_t got);
            fleet_result_t want;
            if (results_due.size() == 0) begin
                $error("fleet result %h arrived with nothing pending", got);
                mismatch_count++;
                return;
            end
            want = results_due.pop_front();
            compare_field("fleet_valid", want.valid, got.valid);
            compare_field("fleet_conflict", want.conflict, got.conflict);
            compare_field("running_units", want.units, got.units);
            compare_field("total_rated", want.rated, got.rated);
            compare_field("total_measured", want.measured, got.measured);
            compare_field("total_required", want.required, got.required);
            compare_field("pv_headroom", want.headroom, got.headroom);
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [gfph_pkg::S_DATA_W-1:0] s_tdata;
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [gfph_pkg::M_DATA_W-1:0] m_tdata;

    fleet_tally tally = new();

    // Idle odds in percent for the sender and the receiver; the main process
    // changes them from phase to phase.
    int send_idle_pct;
    int drain_idle_pct;
    int items_sent;
    int cycle_count;

    generator_fleet_pv_headroom_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // The receiver decides on each falling edge whether it takes a result on
    // the next rising edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= drain_idle_pct);
    end

    // Result transfers are sampled on the rising edge, where both sides of
    // the handshake are settled.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tally.check_fleet_result(m_tdata);
        end
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Called at a falling edge. Idles at random, offers the channel, waits for
    // the transfer, notes it in the tally, and returns at the next falling
    // edge without touching s_tvalid there.
    task automatic send_channel(input channel_word_t c, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        tally.take_channel(c, last);
        @(negedge aclk);
    endtask

    // Stops offering channels until every owed result has come back.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (tally.results_due.size() != 0) @(negedge aclk);
    endtask

    function automatic channel_word_t make_channel(logic [4:0] flags, int rating, int loading,
                                                   int reserve, int margin, int metered,
                                                   int load);
        channel_word_t c;
        c = '0;
        {c.meter_fresh, c.machine_running, c.breaker_on, c.evidence_ok,
         c.configured}  = flags;
        c.rating        = 24'(rating);
        c.loading       = 16'(loading);
        c.reserve       = 24'(reserve);
        c.margin        = 24'(margin);
        c.metered       = 24'(metered);
        c.facility_load = 24'(load);
        return c;
    endfunction

    function automatic logic signed [23:0] random_load();
        case ($urandom_range(0, 3))
            0: return 24'($urandom());
            1: return 24'($urandom_range(0, 200000));
            2: return 24'($urandom_range(0, 24'h7FFFFF));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 24'h800000;
                    1: return 24'h7FFFFF;
                    2: return 24'h000000;
                    default: return 24'hFFFFFF;
                endcase
            end
        endcase
    endfunction

    // Small powers with odds of small_odds in four, so that headroom is often
    // positive, with full-range values mixed in.
    function automatic logic signed [23:0] random_power(int small_odds);
        if ($urandom_range(0, 3) < small_odds) return 24'($urandom_range(0, 5000));
        return 24'($urandom_range(0, 24'h7FFFFF));
    endfunction

    // A channel that passes every check, open or closed.
    function automatic channel_word_t sound_channel();
        channel_word_t c;
        c                 = '0;
        c.configured      = ($urandom_range(0, 9) != 0);
        c.evidence_ok     = 1'b1;
        c.breaker_on      = ($urandom_range(0, 3) != 0);
        c.machine_running = c.breaker_on ? 1'b1 : 1'($urandom_range(0, 1));
        c.meter_fresh     = c.breaker_on ? 1'b1 : 1'($urandom_range(0, 1));
        c.rating          = $urandom_range(0, 1) ? 24'($urandom_range(1, 20000))
                                                 : 24'($urandom_range(1, 24'h7FFFFF));
        c.loading         = 16'($urandom_range(0, 10000));
        c.reserve         = random_power(3);
        c.margin          = random_power(3);
        c.metered         = random_power(2);
        c.facility_load   = random_load();
        return c;
    endfunction

    // A commissioned channel with at least one check broken.
    function automatic channel_word_t broken_channel();
        channel_word_t c;
        c            = sound_channel();
        c.configured = 1'b1;
        case ($urandom_range(0, 7))
            0: c.evidence_ok = 1'b0;
            1: c.rating = $urandom_range(0, 1) ? 24'h000000 : 24'h800000 | 24'($urandom());
            2: c.loading = $urandom_range(0, 1) ? 16'h8000 | 16'($urandom())
                                                : 16'($urandom_range(10001, 32767));
            3: c.reserve = 24'h800000 | 24'($urandom());
            4: c.margin = 24'h800000 | 24'($urandom());
            5: begin
                c.breaker_on      = 1'b1;
                c.machine_running = 1'b0;
            end
            6: begin
                c.breaker_on      = 1'b1;
                c.machine_running = 1'b1;
                c.meter_fresh     = 1'b0;
            end
            default: begin
                c.breaker_on      = 1'b1;
                c.machine_running = 1'b1;
                c.metered         = 24'h800000 | 24'($urandom());
            end
        endcase
        return c;
    endfunction

    // Every field fully random; the padding bits stay zero.
    function automatic channel_word_t noise_channel();
        channel_word_t c;
        c     = {$urandom(), $urandom(), $urandom(), $urandom(), 16'($urandom())};
        c.pad = '0;
        return c;
    endfunction

    // One fleet of random length, sometimes past the channel limit.
    task automatic send_fleet();
        channel_word_t c;
        int            channels;
        int            roll;
        channels = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
        for (int i = 0; i < channels; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 85) c = sound_channel();
            else if (roll < 95) c = broken_channel();
            else c = noise_channel();
            send_channel(c, i == channels - 1);
            items_sent++;
        end
    endtask

    task automatic run_directed();
        // Largest legal channel, then a rounding tie: 1 x 50.00 % gives 0.5,
        // which rounds up to 1. The load is below the required sum, so the
        // headroom clamps at zero.
        send_channel(make_channel(CLOSED_OK, 8388607, 10000, 8388607, 8388607, 8388607, 0), 0);
        send_channel(make_channel(CLOSED_OK, 1, 5000, 0, 0, 0, 8388607), 1);
        // Nothing commissioned, then commissioned but nothing running.
        send_channel(make_channel(UNCOMMISSIONED, 100, 100, 0, 0, 0, 100), 1);
        send_channel(make_channel(OPEN_OK, 100, 0, 0, 0, 0, 100), 1);
        // Each channel check on its own, as one-channel fleets.
        send_channel(make_channel(NO_EVIDENCE, 100, 100, 0, 0, 0, 100), 1);
        send_channel(make_channel(CLOSED_OK, 0, 100, 0, 0, 0, 100), 1);
        send_channel(make_channel(CLOSED_OK, -8388608, 100, 0, 0, 0, 100), 1);
        send_channel(make_channel(CLOSED_OK, 100, -1, 0, 0, 0, 100), 1);
        send_channel(make_channel(CLOSED_OK, 100, 10001, 0, 0, 0, 100), 1);
        send_channel(make_channel(CLOSED_OK, 100, -32768, 0, 0, 0, 100), 1);
        send_channel(make_channel(CLOSED_OK, 100, 32767, 0, 0, 0, 100), 1);
        send_channel(make_channel(CLOSED_OK, 100, 100, -1, 0, 0, 100), 1);
        send_channel(make_channel(CLOSED_OK, 100, 100, 0, -8388608, 0, 100), 1);
        send_channel(make_channel(STOPPED_CLOSED, 100, 100, 0, 0, 0, 100), 1);
        send_channel(make_channel(STALE_METER, 100, 100, 0, 0, 0, 100), 1);
        send_channel(make_channel(CLOSED_OK, 100, 100, 0, 0, -1, 100), 1);
        // A latched conflict hides a later good channel.
        send_channel(make_channel(NO_EVIDENCE, 100, 100, 0, 0, 0, 100), 0);
        send_channel(make_channel(CLOSED_OK, 500, 100, 0, 0, 10, 100000), 1);
        // Valid fleet with the most negative plant load.
        send_channel(make_channel(CLOSED_OK, 1000, 3000, 10, 10, 500, -8388608), 1);
        // One channel more than the fleet limit allows.
        for (int i = 0; i <= gfph_pkg::MAX_CHANNELS; i++) begin
            send_channel(make_channel(CLOSED_OK, 1000, 2500, 5, 5, 900, 4000000),
                         i == gfph_pkg::MAX_CHANNELS);
        end
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        send_idle_pct  = 11;
        drain_idle_pct = 69;
        items_sent     = 0;
        cycle_count    = 0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Three phases: a slow receiver, then a slow sender, then full rate.
        // Between phases the sender waits until every result is back.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 11;
                    drain_idle_pct = 69;
                end
                1: begin
                    send_idle_pct  = 69;
                    drain_idle_pct = 11;
                end
                default: begin
                    send_idle_pct  = 0;
                    drain_idle_pct = 0;
                end
            endcase
            if (phase == 0) run_directed();
            while (items_sent < RANDOM_ITEMS * (phase + 1) / 3) send_fleet();
            hold_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tally.mismatch_count == 0 && tally.results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
